// ===== hw/rtl/gss_pkg.sv =====
package gss_pkg;

    // Accumulator and table sizes.
    localparam int ACC_W       = 32;
    localparam int MAX_CLASSES = 16;
    localparam int CLS_W       = $clog2(MAX_CLASSES);
    localparam int NCLS_W      = $clog2(MAX_CLASSES + 1);
    localparam int ADDR_W      = CLS_W + 1;

    // Divider widths: a Q16-shifted accumulator over a sum of two accumulators.
    localparam int DVD_W = ACC_W + 16;
    localparam int DVS_W = ACC_W + 1;

    // Configuration register indexes.
    localparam logic [1:0] REG_FEATURE_INDEX = 2'd0;
    localparam logic [1:0] REG_THRESHOLD     = 2'd1;
    localparam logic [1:0] REG_CLASS_COUNT   = 2'd2;

    // Request to the shared divider.
    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

endpackage

// ===== hw/rtl/gini_split_statistics.sv =====
// Channel   Handshake                 Payload
// input     i_in_valid / o_in_ready   i_action i_feature_number i_feature_value
//                                     i_label i_weight i_last_feature
// output    o_out_valid / i_out_ready o_kind o_decision o_score o_saturated
// config    APB psel/penable/pwrite   paddr[3:0] pwdata prdata pready
//
// A feature element that is not the last of its sample is taken in the idle state;
// a last element also reads its class bin, then writes it back once the output is free.
// A score query uses the shared divider, one quotient bit per cycle, for every class
// probability and side weight. Reset clears the totals, the bin valid bits and the flags.
// A result waits in the output register; the next item is taken meanwhile.
module gini_split_statistics (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [7:0]  i_feature_number,
    input  logic signed [15:0] i_feature_value,
    input  logic [3:0]  i_label,
    input  logic [15:0] i_weight,
    input  logic        i_last_feature,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic        o_decision,
    output logic [15:0] o_score,
    output logic        o_saturated,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gss_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_UPD   = 4'd1;
    localparam logic [3:0] S_QINIT = 4'd2;
    localparam logic [3:0] S_QSIDE = 4'd3;
    localparam logic [3:0] S_QRD   = 4'd4;
    localparam logic [3:0] S_QLD   = 4'd5;
    localparam logic [3:0] S_QDIV  = 4'd6;
    localparam logic [3:0] S_QMUL  = 4'd7;
    localparam logic [3:0] S_QACC  = 4'd8;
    localparam logic [3:0] S_QWT   = 4'd9;
    localparam logic [3:0] S_QWTW  = 4'd10;
    localparam logic [3:0] S_QWFW  = 4'd11;
    localparam logic [3:0] S_QMIX  = 4'd12;
    localparam logic [3:0] S_QSUM  = 4'd13;
    localparam logic [3:0] S_QOUT  = 4'd14;

    localparam int SUM_W = 2 * 16 + 1 + CLS_W;
    localparam int G_W   = SUM_W - 16;
    localparam int MIX_W = 17 + G_W;

    localparam logic [ACC_W-1:0] ACC_MAX = '1;
    localparam logic [16:0]      ONE_Q16 = 17'h10000;

    // Configuration registers.
    logic [7:0]  r_feature_index;
    logic [15:0] r_threshold;
    logic [4:0]  r_class_count;

    // Control and statistics state.
    logic [3:0]       r_state, n_state;
    logic [ACC_W-1:0] r_tot_t, n_tot_t, r_tot_f, n_tot_f;
    logic [15:0]      r_latched, n_latched;
    logic             r_seen, n_seen;
    logic             r_sat, n_sat;
    logic             r_dec, n_dec;
    logic             r_lbl_ok, n_lbl_ok;
    logic [CLS_W-1:0] r_label, n_label;
    logic [15:0]      r_weight, n_weight;

    // Score sequencer registers.
    logic             r_side, n_side;
    logic [NCLS_W-1:0] r_cls, n_cls;
    logic [ACC_W:0]   r_all, n_all;
    logic [16:0]      r_p, n_p;
    logic [32:0]      r_prod, n_prod;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [G_W-1:0]   r_g_t, n_g_t, r_g_f, n_g_f;
    logic [16:0]      r_wt, n_wt, r_wf, n_wf;
    logic [MIX_W-1:0] r_mt, n_mt, r_mf, n_mf;
    logic [15:0]      r_score, n_score;

    // Output register.
    logic        r_ovalid, n_ovalid;
    logic        r_okind, n_okind;
    logic        r_odec, n_odec;
    logic [15:0] r_oscore, n_oscore;
    logic        r_osat, n_osat;

    // Class bin memory: address is {side, class}; valid bits stand for the cleared store.
    logic [ACC_W-1:0]   r_mem [2**ADDR_W];
    logic [2**ADDR_W-1:0] r_mem_valid;
    logic [ACC_W-1:0]   r_rdata;
    logic               r_rdv;
    logic               w_rd_en, w_wr_en;
    logic [ADDR_W-1:0]  w_rd_addr, w_wr_addr;
    logic [ACC_W-1:0]   w_wr_data;
    logic [ACC_W-1:0]   w_bin;

    t_div_req          w_div_req;
    logic              w_div_done;
    logic [DVD_W-1:0]  w_quo;

    logic [NCLS_W-1:0] w_ncls;
    logic              w_in_fire, w_slot_free, w_cfg_wr;

    assign pready      = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_slot_free = !r_ovalid || i_out_ready;
    assign w_cfg_wr    = psel && penable && pwrite;
    assign w_ncls      = (r_class_count > 5'(MAX_CLASSES)) ? NCLS_W'(MAX_CLASSES)
                                                           : NCLS_W'(r_class_count);
    assign w_bin       = r_rdv ? r_rdata : '0;

    // Register read back.
    always_comb begin
        case (paddr[3:2])
            REG_FEATURE_INDEX: prdata = {24'd0, r_feature_index};
            REG_THRESHOLD:     prdata = {16'd0, r_threshold};
            REG_CLASS_COUNT:   prdata = {27'd0, r_class_count};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feature_index <= '0;
            r_threshold     <= '0;
            r_class_count   <= 5'd2;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_FEATURE_INDEX: r_feature_index <= pwdata[7:0];
                REG_THRESHOLD:     r_threshold     <= pwdata[15:0];
                REG_CLASS_COUNT:   r_class_count   <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    // Sequencer for sample updates and score queries.
    always_comb begin
        logic             v_match;
        logic [15:0]      v_val;
        logic             v_seen;
        logic             v_dec;
        logic [ACC_W:0]   v_bsum, v_tsum;
        logic [ACC_W-1:0] v_tot;
        logic [SUM_W-1:0] v_acc;
        logic [MIX_W:0]   v_mix;

        n_state = r_state;   n_tot_t = r_tot_t;   n_tot_f = r_tot_f;
        n_latched = r_latched; n_seen = r_seen;   n_sat = r_sat;
        n_dec = r_dec;       n_lbl_ok = r_lbl_ok; n_label = r_label;
        n_weight = r_weight; n_side = r_side;     n_cls = r_cls;
        n_all = r_all;       n_p = r_p;           n_prod = r_prod;
        n_sum = r_sum;       n_g_t = r_g_t;       n_g_f = r_g_f;
        n_wt = r_wt;         n_wf = r_wf;         n_mt = r_mt;
        n_mf = r_mf;         n_score = r_score;
        n_ovalid = r_ovalid && !i_out_ready;
        n_okind = r_okind;   n_odec = r_odec;     n_oscore = r_oscore;
        n_osat = r_osat;
        w_rd_en = 1'b0;      w_rd_addr = '0;
        w_wr_en = 1'b0;      w_wr_addr = {r_dec, r_label};
        w_wr_data = '0;
        w_div_req = '0;

        v_match = (i_feature_number == r_feature_index);
        v_val   = v_match ? i_feature_value : r_latched;
        v_seen  = v_match || r_seen;
        v_dec   = v_seen && ($signed(v_val) > $signed(r_threshold));
        v_tot   = r_side ? r_tot_t : r_tot_f;
        v_bsum  = {1'b0, w_bin} + {{(ACC_W-15){1'b0}}, r_weight};
        v_tsum  = (r_dec ? {1'b0, r_tot_t} : {1'b0, r_tot_f})
                + {{(ACC_W-15){1'b0}}, r_weight};
        v_acc   = r_sum + SUM_W'(r_prod);
        v_mix   = {1'b0, r_mt} + {1'b0, r_mf};

        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    if (i_action) begin
                        n_state = S_QINIT;
                    end else begin
                        n_latched = v_val;
                        n_seen    = v_seen;
                        if (i_last_feature) begin
                            n_seen    = 1'b0;
                            n_dec     = v_dec;
                            n_label   = i_label;
                            n_lbl_ok  = (NCLS_W'(i_label) < w_ncls);
                            n_weight  = i_weight;
                            w_rd_en   = 1'b1;
                            w_rd_addr = {v_dec, i_label};
                            n_state   = S_UPD;
                        end
                    end
                end
            end
            S_UPD: begin
                if (w_slot_free) begin
                    if (r_lbl_ok) begin
                        w_wr_en   = 1'b1;
                        w_wr_data = v_bsum[ACC_W] ? ACC_MAX : v_bsum[ACC_W-1:0];
                        if (r_dec) n_tot_t = v_tsum[ACC_W] ? ACC_MAX : v_tsum[ACC_W-1:0];
                        else       n_tot_f = v_tsum[ACC_W] ? ACC_MAX : v_tsum[ACC_W-1:0];
                        n_sat = r_sat || v_bsum[ACC_W] || v_tsum[ACC_W];
                    end
                    n_ovalid = 1'b1;
                    n_okind  = 1'b0;
                    n_odec   = r_dec;
                    n_oscore = '0;
                    n_osat   = r_sat || (r_lbl_ok && (v_bsum[ACC_W] || v_tsum[ACC_W]));
                    n_state  = S_IDLE;
                end
            end
            S_QINIT: begin
                n_all = {1'b0, r_tot_t} + {1'b0, r_tot_f};
                n_side = 1'b1;
                n_cls  = '0;
                n_sum  = '0;
                if (n_all == '0) begin
                    n_score = '0;
                    n_state = S_QOUT;
                end else begin
                    n_state = S_QSIDE;
                end
            end
            S_QSIDE: begin
                if (v_tot == '0 || w_ncls == '0) begin
                    if (r_side) n_g_t = '0;
                    else        n_g_f = '0;
                    n_side  = 1'b0;
                    n_cls   = '0;
                    n_sum   = '0;
                    n_state = r_side ? S_QSIDE : S_QWT;
                end else begin
                    n_state = S_QRD;
                end
            end
            S_QRD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = {r_side, r_cls[CLS_W-1:0]};
                n_state   = S_QLD;
            end
            S_QLD: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = {w_bin, 16'd0};
                w_div_req.divisor  = {1'b0, v_tot};
                n_state = S_QDIV;
            end
            S_QDIV: begin
                if (w_div_done) begin
                    n_p = (w_quo > DVD_W'(ONE_Q16)) ? ONE_Q16 : w_quo[16:0];
                    n_state = S_QMUL;
                end
            end
            S_QMUL: begin
                n_prod  = 33'(r_p) * 33'(ONE_Q16 - r_p);
                n_state = S_QACC;
            end
            S_QACC: begin
                n_sum = v_acc;
                n_cls = r_cls + 1'b1;
                n_state = S_QRD;
                if (r_cls + 1'b1 == w_ncls) begin
                    if (r_side) n_g_t = v_acc[SUM_W-1:16];
                    else        n_g_f = v_acc[SUM_W-1:16];
                    n_side  = 1'b0;
                    n_cls   = '0;
                    n_sum   = '0;
                    n_state = r_side ? S_QSIDE : S_QWT;
                end
            end
            S_QWT: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = {r_tot_t, 16'd0};
                w_div_req.divisor  = r_all;
                n_state = S_QWTW;
            end
            S_QWTW: begin
                if (w_div_done) begin
                    n_wt = w_quo[16:0];
                    w_div_req.start    = 1'b1;
                    w_div_req.dividend = {r_tot_f, 16'd0};
                    w_div_req.divisor  = r_all;
                    n_state = S_QWFW;
                end
            end
            S_QWFW: begin
                if (w_div_done) begin
                    n_wf    = w_quo[16:0];
                    n_state = S_QMIX;
                end
            end
            S_QMIX: begin
                n_mt    = r_wt * r_g_t;
                n_mf    = r_wf * r_g_f;
                n_state = S_QSUM;
            end
            S_QSUM: begin
                n_score = (v_mix[MIX_W:16] > (MIX_W-15)'(16'hFFFF)) ? 16'hFFFF
                                                                   : v_mix[31:16];
                n_state = S_QOUT;
            end
            S_QOUT: begin
                if (w_slot_free) begin
                    n_ovalid = 1'b1;
                    n_okind  = 1'b1;
                    n_odec   = 1'b0;
                    n_oscore = r_score;
                    n_osat   = r_sat;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tot_t     <= '0;
            r_tot_f     <= '0;
            r_latched   <= '0;
            r_seen      <= 1'b0;
            r_sat       <= 1'b0;
            r_ovalid    <= 1'b0;
            r_mem_valid <= '0;
        end else begin
            r_state   <= n_state;
            r_tot_t   <= n_tot_t;
            r_tot_f   <= n_tot_f;
            r_latched <= n_latched;
            r_seen    <= n_seen;
            r_sat     <= n_sat;
            r_ovalid  <= n_ovalid;
            if (w_wr_en) r_mem_valid[w_wr_addr] <= 1'b1;
        end
        r_dec    <= n_dec;    r_lbl_ok <= n_lbl_ok; r_label <= n_label;
        r_weight <= n_weight; r_side   <= n_side;   r_cls   <= n_cls;
        r_all    <= n_all;    r_p      <= n_p;      r_prod  <= n_prod;
        r_sum    <= n_sum;    r_g_t    <= n_g_t;    r_g_f   <= n_g_f;
        r_wt     <= n_wt;     r_wf     <= n_wf;     r_mt    <= n_mt;
        r_mf     <= n_mf;     r_score  <= n_score;
        r_okind  <= n_okind;  r_odec   <= n_odec;   r_oscore <= n_oscore;
        r_osat   <= n_osat;
    end

    // Bin memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[w_wr_addr] <= w_wr_data;
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
            r_rdv   <= r_mem_valid[w_rd_addr];
        end
    end

    gss_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign o_out_valid = r_ovalid;
    assign o_kind      = r_okind;
    assign o_decision  = r_odec;
    assign o_score     = r_oscore;
    assign o_saturated = r_osat;

endmodule

// ===== hw/rtl/gss_div.sv =====
module gss_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  gss_pkg::t_div_req        i_req,
    output logic                     o_done,
    output logic [gss_pkg::DVD_W-1:0] o_quotient
);
    import gss_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_dvd, n_dvd;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVS_W-1:0] r_dvs, n_dvs;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_done, n_done;
    logic [DVS_W:0]   w_shift;
    logic [DVS_W:0]   w_diff;

    // One quotient bit per cycle, restoring form; quotient shifts into the dividend.
    always_comb begin
        w_shift = {r_rem, r_dvd[DVD_W-1]};
        w_diff  = w_shift - {1'b0, r_dvs};
        n_dvd   = r_dvd;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        if (i_req.start) begin
            n_dvd = i_req.dividend;
            n_rem = '0;
            n_dvs = i_req.divisor;
            n_cnt = CNT_W'(DVD_W);
        end else if (r_cnt != '0) begin
            if (!w_diff[DVS_W]) begin
                n_rem = w_diff[DVS_W-1:0];
                n_dvd = {r_dvd[DVD_W-2:0], 1'b1};
            end else begin
                n_rem = w_shift[DVS_W-1:0];
                n_dvd = {r_dvd[DVD_W-2:0], 1'b0};
            end
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd;

endmodule
